// ----- design/qhd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhd_pkg
// Shared types, constellation tables and helper functions for the QAM
// hard-decision demapper.
// ----------------------------------------------------------------------------
package qhd_pkg;

    // Constellation select
    typedef enum logic [1:0] {
        MODE_BPSK  = 2'd0,
        MODE_QPSK  = 2'd1,
        MODE_QAM16 = 2'd2,
        MODE_QAM64 = 2'd3
    } mode_t;

    // Width of a symbol index and of a constellation level (Q1.12)
    localparam int IDX_W   = 6;
    localparam int LEVEL_W = 14;
    localparam int COUNT_W = 3;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [COUNT_W-1:0]        count_t;

    // Per-axis levels, unit mean power, Q1.12
    localparam level_t BPSK_LEVEL = 14'sd4096;
    localparam level_t AXIS_QPSK [2] = '{-14'sd2896, 14'sd2896};
    localparam level_t AXIS_Q16  [4] = '{-14'sd3886, -14'sd1295, 14'sd3886, 14'sd1295};
    localparam level_t AXIS_Q64  [8] = '{-14'sd4424, -14'sd3160, -14'sd632, -14'sd1896,
                                         14'sd4424,  14'sd3160,  14'sd632,  14'sd1896};

    // In-phase level of point k; upper half of the index selects it
    function automatic level_t point_i(mode_t m, idx_t k);
        level_t lvl;
        case (m)
            MODE_BPSK:  lvl = k[0] ? -BPSK_LEVEL : BPSK_LEVEL;
            MODE_QPSK:  lvl = AXIS_QPSK[k[1]];
            MODE_QAM16: lvl = AXIS_Q16[k[3:2]];
            MODE_QAM64: lvl = AXIS_Q64[k[5:3]];
            default:    lvl = '0;
        endcase
        return lvl;
    endfunction

    // Quadrature level of point k; negated axis entry from the lower half
    function automatic level_t point_q(mode_t m, idx_t k);
        level_t lvl;
        case (m)
            MODE_BPSK:  lvl = '0;
            MODE_QPSK:  lvl = -AXIS_QPSK[k[0]];
            MODE_QAM16: lvl = -AXIS_Q16[k[1:0]];
            MODE_QAM64: lvl = -AXIS_Q64[k[2:0]];
            default:    lvl = '0;
        endcase
        return lvl;
    endfunction

    // Number of decided bits per symbol
    function automatic count_t bits_of(mode_t m);
        count_t n;
        case (m)
            MODE_BPSK:  n = 3'd1;
            MODE_QPSK:  n = 3'd2;
            MODE_QAM16: n = 3'd4;
            MODE_QAM64: n = 3'd6;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    // Point k exists in the selected constellation
    function automatic logic point_used(mode_t m, idx_t k);
        logic ok;
        case (m)
            MODE_BPSK:  ok = (k[IDX_W-1:1] == '0);
            MODE_QPSK:  ok = (k[IDX_W-1:2] == '0);
            MODE_QAM16: ok = (k[IDX_W-1:4] == '0);
            MODE_QAM64: ok = 1'b1;
            default:    ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ----- design/qam_hard_decision_demapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qam_hard_decision_demapper
// Minimum-distance hard demapper for BPSK, QPSK, 16-QAM and 64-QAM.
//
// Usage:
//   Input channel: drive in_phase/quadrature (signed Q3.12) with start high;
//   the word is taken at every clock edge with start high, since busy is
//   always low. A new word may follow every cycle.
//   Result channel: done pulses for one cycle with symbol_bits (nearest point
//   index, MSB-first decided bits) and bit_count (1, 2, 4 or 6). The
//   receiver cannot stall; results appear in input order.
//   Configuration: cfg_we with cfg_data selects the constellation
//   (0 BPSK, 1 QPSK, 2 16-QAM, 3 64-QAM); write only while no word is in
//   flight.
// Throughput: one word per cycle. Each point of the constellation has its
//   own cell in a chain; a cell squares its point's error and the next
//   cell folds that distance into the running best, so the chain length
//   sets the latency.
// Reset: mode returns to BPSK and all words in flight are dropped.
// ----------------------------------------------------------------------------
module qam_hard_decision_demapper
    import qhd_pkg::*;
#(
    parameter int MAX_POINTS   = 64,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] in_phase,
    input  logic signed [SAMPLE_WIDTH-1:0] quadrature,
    output logic                           done,
    output logic [IDX_W-1:0]               symbol_bits,
    output logic [COUNT_W-1:0]             bit_count
);

    // Error width covers sample range plus the largest level
    localparam int DIW = ((SAMPLE_WIDTH > LEVEL_W) ? SAMPLE_WIDTH : LEVEL_W) + 1;
    localparam int SQW = 2 * DIW;
    localparam int DW  = SQW + 1;

    mode_t mode_reg;

    // Links between cells; link 0 is the chain input
    logic                           valid_w [MAX_POINTS+1];
    logic signed [SAMPLE_WIDTH-1:0] si_w    [MAX_POINTS+1];
    logic signed [SAMPLE_WIDTH-1:0] sq_w    [MAX_POINTS+1];
    idx_t                           bidx_w  [MAX_POINTS+1];
    logic [DW-1:0]                  bdist_w [MAX_POINTS+1];
    logic [SQW-1:0]                 di2_w   [MAX_POINTS+1];
    logic [SQW-1:0]                 dq2_w   [MAX_POINTS+1];
    logic                           ok_w    [MAX_POINTS+1];

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BPSK;
        end
        else if (cfg_we)
        begin
            mode_reg <= mode_t'(cfg_data);
        end
    end

    // Chain input: no pending point, best distance starts above any real one
    assign busy       = 1'b0;
    assign valid_w[0] = start;
    assign si_w[0]    = in_phase;
    assign sq_w[0]    = quadrature;
    assign bidx_w[0]  = '0;
    assign bdist_w[0] = '1;
    assign di2_w[0]   = '0;
    assign dq2_w[0]   = '0;
    assign ok_w[0]    = 1'b0;

    // One cell per constellation point
    for (genvar k = 0; k < MAX_POINTS; k++)
    begin : g_cell
        qhd_cell #(
            .INDEX        (k),
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .DIW          (DIW),
            .SQW          (SQW),
            .DW           (DW)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .mode          (mode_reg),
            .valid_in      (valid_w[k]),
            .si_in         (si_w[k]),
            .sq_in         (sq_w[k]),
            .best_idx_in   (bidx_w[k]),
            .best_dist_in  (bdist_w[k]),
            .pend_di2_in   (di2_w[k]),
            .pend_dq2_in   (dq2_w[k]),
            .pend_ok_in    (ok_w[k]),
            .valid_out     (valid_w[k+1]),
            .si_out        (si_w[k+1]),
            .sq_out        (sq_w[k+1]),
            .best_idx_out  (bidx_w[k+1]),
            .best_dist_out (bdist_w[k+1]),
            .pend_di2_out  (di2_w[k+1]),
            .pend_dq2_out  (dq2_w[k+1]),
            .pend_ok_out   (ok_w[k+1])
        );
    end

    // Tail: last point and output register
    qhd_pick #(
        .LAST_INDEX (MAX_POINTS - 1),
        .SQW        (SQW),
        .DW         (DW)
    ) u_pick (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .valid_in     (valid_w[MAX_POINTS]),
        .best_idx_in  (bidx_w[MAX_POINTS]),
        .best_dist_in (bdist_w[MAX_POINTS]),
        .pend_di2_in  (di2_w[MAX_POINTS]),
        .pend_dq2_in  (dq2_w[MAX_POINTS]),
        .pend_ok_in   (ok_w[MAX_POINTS]),
        .done         (done),
        .symbol_bits  (symbol_bits),
        .bit_count    (bit_count)
    );

endmodule

// ----- design/qhd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhd_cell
// One cell of the search chain. Squares the I/Q error of its own point and
// hands it on, and settles the point handed in by the previous cell against
// the running best.
// ----------------------------------------------------------------------------
module qhd_cell
    import qhd_pkg::*;
#(
    parameter int INDEX        = 0,
    parameter int SAMPLE_WIDTH = 16,
    parameter int DIW          = 17,
    parameter int SQW          = 2 * DIW,
    parameter int DW           = SQW + 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mode_t                          mode,
    input  logic                           valid_in,
    input  logic signed [SAMPLE_WIDTH-1:0] si_in,
    input  logic signed [SAMPLE_WIDTH-1:0] sq_in,
    input  idx_t                           best_idx_in,
    input  logic [DW-1:0]                  best_dist_in,
    input  logic [SQW-1:0]                 pend_di2_in,
    input  logic [SQW-1:0]                 pend_dq2_in,
    input  logic                           pend_ok_in,
    output logic                           valid_out,
    output logic signed [SAMPLE_WIDTH-1:0] si_out,
    output logic signed [SAMPLE_WIDTH-1:0] sq_out,
    output idx_t                           best_idx_out,
    output logic [DW-1:0]                  best_dist_out,
    output logic [SQW-1:0]                 pend_di2_out,
    output logic [SQW-1:0]                 pend_dq2_out,
    output logic                           pend_ok_out
);

    // Index of the point whose squares arrive from the previous cell
    localparam idx_t PEND_IDX = IDX_W'((INDEX > 0) ? (INDEX - 1) : 0);
    localparam idx_t OWN_IDX  = IDX_W'(INDEX);

    logic                           valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] si_reg;
    logic signed [SAMPLE_WIDTH-1:0] sq_reg;
    idx_t                           best_idx_reg,  best_idx_next;
    logic [DW-1:0]                  best_dist_reg, best_dist_next;
    logic [SQW-1:0]                 di2_reg,       di2_next;
    logic [SQW-1:0]                 dq2_reg,       dq2_next;
    logic                           ok_reg,        ok_next;

    logic [DW-1:0]          pend_dist;
    logic                   take;
    logic signed [DIW-1:0]  di;
    logic signed [DIW-1:0]  dq;
    logic signed [SQW-1:0]  di_sq;
    logic signed [SQW-1:0]  dq_sq;

    // Settle the pending point; strict less keeps the lower index on a tie
    always_comb
    begin
        pend_dist      = DW'(pend_di2_in) + DW'(pend_dq2_in);
        take           = pend_ok_in && (pend_dist < best_dist_in);
        best_idx_next  = take ? PEND_IDX  : best_idx_in;
        best_dist_next = take ? pend_dist : best_dist_in;
    end

    // Squared error of this cell's own point
    always_comb
    begin
        di       = DIW'(si_in) - DIW'(point_i(mode, OWN_IDX));
        dq       = DIW'(sq_in) - DIW'(point_q(mode, OWN_IDX));
        di_sq    = di * di;
        dq_sq    = dq * dq;
        di2_next = $unsigned(di_sq);
        dq2_next = $unsigned(dq_sq);
        ok_next  = point_used(mode, OWN_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        si_reg        <= si_in;
        sq_reg        <= sq_in;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        di2_reg       <= di2_next;
        dq2_reg       <= dq2_next;
        ok_reg        <= ok_next;
    end

    assign valid_out     = valid_reg;
    assign si_out        = si_reg;
    assign sq_out        = sq_reg;
    assign best_idx_out  = best_idx_reg;
    assign best_dist_out = best_dist_reg;
    assign pend_di2_out  = di2_reg;
    assign pend_dq2_out  = dq2_reg;
    assign pend_ok_out   = ok_reg;

endmodule

// ----- design/qhd_pick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhd_pick
// Tail of the search chain: settles the last point and registers the
// decided word with its bit count.
// ----------------------------------------------------------------------------
module qhd_pick
    import qhd_pkg::*;
#(
    parameter int LAST_INDEX = 63,
    parameter int SQW        = 34,
    parameter int DW         = SQW + 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  mode_t          mode,
    input  logic           valid_in,
    input  idx_t           best_idx_in,
    input  logic [DW-1:0]  best_dist_in,
    input  logic [SQW-1:0] pend_di2_in,
    input  logic [SQW-1:0] pend_dq2_in,
    input  logic           pend_ok_in,
    output logic           done,
    output idx_t           symbol_bits,
    output count_t         bit_count
);

    localparam idx_t PEND_IDX = IDX_W'(LAST_INDEX);

    logic          done_reg;
    idx_t          symbol_reg, symbol_next;
    count_t        count_reg,  count_next;
    logic [DW-1:0] pend_dist;

    // Final compare
    always_comb
    begin
        pend_dist   = DW'(pend_di2_in) + DW'(pend_dq2_in);
        symbol_next = (pend_ok_in && (pend_dist < best_dist_in)) ? PEND_IDX : best_idx_in;
        count_next  = bits_of(mode);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
        count_reg  <= count_next;
    end

    assign done        = done_reg;
    assign symbol_bits = symbol_reg;
    assign bit_count   = count_reg;

endmodule
